@@ rtl/imhq_pkg.sv @@
// Shared types and constants for the indexed max-heap queue.
package imhq_pkg;

    localparam int MaxIds   = 256;
    localparam int IdW      = 8;
    localparam int PrioW    = 32;
    localparam int CountW   = 9;
    localparam int ModeW    = 3;

    localparam logic [ModeW-1:0] MODE_INSERT   = 3'd0;
    localparam logic [ModeW-1:0] MODE_INCREASE = 3'd1;
    localparam logic [ModeW-1:0] MODE_DECREASE = 3'd2;
    localparam logic [ModeW-1:0] MODE_REMOVE   = 3'd3;
    localparam logic [ModeW-1:0] MODE_QUERY    = 3'd4;

    localparam logic [CountW-1:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic signed [PrioW-1:0] prio;
        logic [IdW-1:0]          id;
    } entry_t;

    localparam int EntryW = $bits(entry_t);

    typedef struct packed {
        logic                    ok;
        logic [IdW-1:0]          id;
        logic signed [PrioW-1:0] prio;
        logic [CountW-1:0]       count;
    } result_t;

endpackage

@@ rtl/imhq_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/imhq_ctrl.sv @@
// Operation sequencer: lookups, sift up and sift down over the heap memories.
module imhq_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           op_valid,
    output logic                           op_ready,
    input  logic [imhq_pkg::ModeW-1:0]     op_mode,
    input  logic [imhq_pkg::IdW-1:0]       op_id,
    input  logic [imhq_pkg::PrioW-1:0]     op_prio,
    input  logic [imhq_pkg::CountW-1:0]    capacity,
    output logic                           heap_we,
    output logic [imhq_pkg::IdW-1:0]       heap_waddr,
    output imhq_pkg::entry_t               heap_wdata,
    output logic [imhq_pkg::IdW-1:0]       heap_raddr,
    input  imhq_pkg::entry_t               heap_rdata,
    output logic                           pos_we,
    output logic [imhq_pkg::IdW-1:0]       pos_waddr,
    output logic [imhq_pkg::IdW-1:0]       pos_wdata,
    output logic [imhq_pkg::IdW-1:0]       pos_raddr,
    input  logic [imhq_pkg::IdW-1:0]       pos_rdata,
    input  logic                           res_ready,
    output logic                           res_valid,
    output imhq_pkg::result_t              res
);
    import imhq_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_LK_POS  = 12'b0000_0000_0010,
        ST_LK_SLOT = 12'b0000_0000_0100,
        ST_RM_TOP  = 12'b0000_0000_1000,
        ST_RM_LAST = 12'b0000_0001_0000,
        ST_UP_RD   = 12'b0000_0010_0000,
        ST_UP_CMP  = 12'b0000_0100_0000,
        ST_DN_RDL  = 12'b0000_1000_0000,
        ST_DN_RDR  = 12'b0001_0000_0000,
        ST_DN_CMP  = 12'b0010_0000_0000,
        ST_FIN     = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [ModeW-1:0]    mode_reg, mode_next;
    logic [IdW-1:0]      id_reg, id_next;
    logic signed [PrioW-1:0] req_reg, req_next;
    entry_t              cur_reg, cur_next;
    entry_t              left_reg, left_next;
    logic [IdW-1:0]      pos_reg, pos_next;
    logic [CountW-1:0]   cnt_reg, cnt_next;
    logic                ok_reg, ok_next;
    logic [IdW-1:0]      oid_reg, oid_next;
    logic signed [PrioW-1:0] oprio_reg, oprio_next;
    logic [MaxIds-1:0]   present_reg, present_next;

    logic                id_ok;
    logic [IdW-1:0]      parent;
    logic [CountW-1:0]   left_idx;
    logic [CountW-1:0]   right_idx;
    logic                right_ok;
    logic                take_left;
    entry_t              pick;
    logic [IdW-1:0]      pick_idx;

    always_comb begin
        id_ok     = {1'b0, op_id} < capacity;
        parent    = (pos_reg - 8'd1) >> 1;
        left_idx  = {pos_reg, 1'b1};
        right_idx = left_idx + 9'd1;
        right_ok  = right_idx < cnt_reg;
        take_left = !right_ok || (left_reg.prio > heap_rdata.prio);
        pick      = take_left ? left_reg : heap_rdata;
        pick_idx  = take_left ? left_idx[IdW-1:0] : right_idx[IdW-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        id_next      = id_reg;
        req_next     = req_reg;
        cur_next     = cur_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        ok_next      = ok_reg;
        oid_next     = oid_reg;
        oprio_next   = oprio_reg;
        present_next = present_reg;
        heap_we      = 1'b0;
        heap_waddr   = pos_reg;
        heap_wdata   = cur_reg;
        heap_raddr   = '0;
        pos_we       = 1'b0;
        pos_waddr    = cur_reg.id;
        pos_wdata    = pos_reg;
        pos_raddr    = op_id;
        op_ready     = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                op_ready = 1'b1;
                if (op_valid) begin
                    mode_next  = op_mode;
                    id_next    = op_id;
                    req_next   = op_prio;
                    ok_next    = 1'b0;
                    oid_next   = op_id;
                    oprio_next = '0;
                    state_next = ST_DONE;
                    case (op_mode) inside
                        MODE_INSERT: begin
                            if (id_ok && !present_reg[op_id] && cnt_reg < capacity
                                    && cnt_reg < CAP_RESET) begin
                                cur_next             = '{prio: op_prio, id: op_id};
                                pos_next             = cnt_reg[IdW-1:0];
                                cnt_next             = cnt_reg + 9'd1;
                                present_next[op_id]  = 1'b1;
                                ok_next              = 1'b1;
                                state_next = (cnt_reg == '0) ? ST_FIN : ST_UP_RD;
                            end
                        end
                        MODE_INCREASE, MODE_DECREASE, MODE_QUERY: begin
                            if (id_ok && present_reg[op_id]) begin
                                state_next = ST_LK_POS;
                            end
                        end
                        MODE_REMOVE: begin
                            if (cnt_reg != '0) begin
                                cnt_next   = cnt_reg - 9'd1;
                                state_next = ST_RM_TOP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LK_POS: begin
                pos_next   = pos_rdata;
                heap_raddr = pos_rdata;
                state_next = ST_LK_SLOT;
            end
            ST_LK_SLOT: begin
                state_next = ST_DONE;
                cur_next   = '{prio: req_reg, id: id_reg};
                case (mode_reg)
                    MODE_QUERY: begin
                        ok_next    = 1'b1;
                        oprio_next = heap_rdata.prio;
                    end
                    MODE_INCREASE: begin
                        if (req_reg > heap_rdata.prio) begin
                            ok_next    = 1'b1;
                            state_next = (pos_reg == '0) ? ST_FIN : ST_UP_RD;
                        end
                    end
                    default: begin
                        if (heap_rdata.prio > req_reg) begin
                            ok_next    = 1'b1;
                            state_next = ST_DN_RDL;
                        end
                    end
                endcase
            end
            ST_RM_TOP: begin
                ok_next                     = 1'b1;
                oid_next                    = heap_rdata.id;
                oprio_next                  = heap_rdata.prio;
                present_next[heap_rdata.id] = 1'b0;
                heap_raddr                  = cnt_reg[IdW-1:0];
                state_next                  = ST_RM_LAST;
            end
            ST_RM_LAST: begin
                cur_next   = heap_rdata;
                pos_next   = '0;
                state_next = ST_DN_RDL;
            end
            ST_UP_RD: begin
                heap_raddr = parent;
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                if (cur_reg.prio > heap_rdata.prio) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = heap_rdata.id;
                    pos_next   = parent;
                    state_next = (parent == '0) ? ST_FIN : ST_UP_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DN_RDL: begin
                heap_raddr = left_idx[IdW-1:0];
                state_next = (left_idx < cnt_reg) ? ST_DN_RDR : ST_FIN;
            end
            ST_DN_RDR: begin
                left_next  = heap_rdata;
                heap_raddr = right_idx[IdW-1:0];
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (cur_reg.prio > pick.prio) begin
                    state_next = ST_FIN;
                end else begin
                    heap_we    = 1'b1;
                    heap_wdata = pick;
                    pos_we     = 1'b1;
                    pos_waddr  = pick.id;
                    pos_next   = pick_idx;
                    state_next = ST_DN_RDL;
                end
            end
            ST_FIN: begin
                heap_we    = 1'b1;
                pos_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid = res_ready;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res = '{ok: ok_reg, id: oid_reg, prio: oprio_reg, count: cnt_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            present_reg <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            present_reg <= present_next;
        end
        mode_reg  <= mode_next;
        id_reg    <= id_next;
        req_reg   <= req_next;
        cur_reg   <= cur_next;
        left_reg  <= left_next;
        pos_reg   <= pos_next;
        ok_reg    <= ok_next;
        oid_reg   <= oid_next;
        oprio_reg <= oprio_next;
    end

endmodule

@@ rtl/indexed_max_heap_queue.sv @@
// Top level: indexed max-heap priority queue with stream ports.
// Sift up reads the parent entry at each level; sift down reads the left and right children.
// One item at a time: a new beat is taken only after the previous result has left the sequencer.
// A finished result may wait in the output register while the next item runs.
// Reset (aresetn low, synchronous): queue empty, capacity 256; no memory clear.
module indexed_max_heap_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // id [7:0], priority_req [39:8]
    input  logic [2:0]  s_tuser,   // mode [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_id [7:0], out_priority [39:8], count [48:40]
    output logic        m_tuser,   // ok [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);
    import imhq_pkg::*;

    logic [CountW-1:0] cap_reg;
    logic              m_valid_reg;
    result_t           out_reg;
    logic              res_ready;
    logic              res_valid;
    result_t           res;

    logic              heap_we;
    logic [IdW-1:0]    heap_waddr;
    entry_t            heap_wdata;
    logic [IdW-1:0]    heap_raddr;
    logic [EntryW-1:0] heap_rdata;
    logic              pos_we;
    logic [IdW-1:0]    pos_waddr;
    logic [IdW-1:0]    pos_wdata;
    logic [IdW-1:0]    pos_raddr;
    logic [IdW-1:0]    pos_rdata;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.ok;
    assign m_tdata  = {7'd0, out_reg.count, out_reg.prio, out_reg.id};

    imhq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_valid   (s_tvalid),
        .op_ready   (s_tready),
        .op_mode    (s_tuser),
        .op_id      (s_tdata[7:0]),
        .op_prio    (s_tdata[39:8]),
        .capacity   (cap_reg),
        .heap_we    (heap_we),
        .heap_waddr (heap_waddr),
        .heap_wdata (heap_wdata),
        .heap_raddr (heap_raddr),
        .heap_rdata (entry_t'(heap_rdata)),
        .pos_we     (pos_we),
        .pos_waddr  (pos_waddr),
        .pos_wdata  (pos_wdata),
        .pos_raddr  (pos_raddr),
        .pos_rdata  (pos_rdata),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    imhq_ram #(.WIDTH(EntryW), .DEPTH(MaxIds)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    imhq_ram #(.WIDTH(IdW), .DEPTH(MaxIds)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

endmodule

@@ test/indexed_max_heap_queue_tb.sv @@
// Self-checking testbench for the indexed max-heap queue: directed cases and random traffic.
module indexed_max_heap_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import imhq_pkg::*;

    localparam int LimitCycles = 900000;

    typedef struct {
        logic            ok;
        logic [7:0]      id;
        logic [31:0]     prio;
        logic [8:0]      count;
    } heap_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;

    indexed_max_heap_queue uut (.*);

    always #4 aclk = ~aclk;

    logic [7:0]  slot_id [MaxIds];
    logic [7:0]  id_slot [MaxIds];
    logic        present [MaxIds];
    logic [31:0] prio_of [MaxIds];
    int          heap_count;
    int          cap_cfg;
    heap_result_t pending_results[$];
    int          errors = 0;
    int          sent = 0;
    int          received = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    longint      cycles = 0;

    function automatic bit prio_gt(logic [31:0] a, logic [31:0] b);
        return $signed(a) > $signed(b);
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [7:0] ia, ib;
        ia = slot_id[a];
        ib = slot_id[b];
        slot_id[a] = ib;
        slot_id[b] = ia;
        id_slot[ib] = 8'(a);
        id_slot[ia] = 8'(b);
    endfunction

    function automatic void heap_up(int pos);
        int parent;
        while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!prio_gt(prio_of[slot_id[pos]], prio_of[slot_id[parent]])) break;
            swap_slots(pos, parent);
            pos = parent;
        end
    endfunction

    function automatic void heap_down(int pos);
        int l, r, pick;
        while (pos < heap_count) begin
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            if (l >= heap_count) break;
            if (r >= heap_count || prio_gt(prio_of[slot_id[l]], prio_of[slot_id[r]]))
                pick = l;
            else
                pick = r;
            if (prio_gt(prio_of[slot_id[pos]], prio_of[slot_id[pick]])) break;
            swap_slots(pos, pick);
            pos = pick;
        end
    endfunction

    function automatic heap_result_t predict_op(logic [2:0] mode, logic [7:0] id,
                                                logic [31:0] req);
        heap_result_t r;
        int cap;
        bit id_ok;
        logic [7:0] top;
        cap = cap_cfg < MaxIds ? cap_cfg : MaxIds;
        id_ok = id < cap;
        r.ok = 1'b0;
        r.id = id;
        r.prio = '0;
        case (mode)
            MODE_INSERT: begin
                if (id_ok && !present[id] && heap_count < cap) begin
                    slot_id[heap_count] = id;
                    id_slot[id] = 8'(heap_count);
                    prio_of[id] = req;
                    present[id] = 1'b1;
                    heap_count++;
                    heap_up(heap_count - 1);
                    r.ok = 1'b1;
                end
            end
            MODE_INCREASE: begin
                if (id_ok && present[id] && prio_gt(req, prio_of[id])) begin
                    prio_of[id] = req;
                    heap_up(id_slot[id]);
                    r.ok = 1'b1;
                end
            end
            MODE_DECREASE: begin
                if (id_ok && present[id] && prio_gt(prio_of[id], req)) begin
                    prio_of[id] = req;
                    heap_down(id_slot[id]);
                    r.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (heap_count > 0) begin
                    top = slot_id[0];
                    r.id = top;
                    r.prio = prio_of[top];
                    present[top] = 1'b0;
                    heap_count--;
                    slot_id[0] = slot_id[heap_count];
                    id_slot[slot_id[0]] = 0;
                    heap_down(0);
                    r.ok = 1'b1;
                end
            end
            MODE_QUERY: begin
                if (id_ok && present[id]) begin
                    r.prio = prio_of[id];
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = 9'(heap_count);
        return r;
    endfunction

    task automatic send_op(logic [2:0] mode, logic [7:0] id, logic [31:0] req);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = {req, id};
        s_tuser = mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_op(mode, id, req));
        sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() > 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_capacity(int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value[8:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cap_cfg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_prio();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        heap_result_t exp_r;
        cycles++;
        if (cycles > LimitCycles) begin
            $display("Verification failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            received++;
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.ok) begin
                    $error("ok: expected %0d actual %0d", exp_r.ok, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== exp_r.id) begin
                    $error("out_id: expected %0d actual %0d", exp_r.id, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[39:8] !== exp_r.prio) begin
                    $error("out_priority: expected %h actual %h", exp_r.prio, m_tdata[39:8]);
                    errors++;
                end
                if (m_tdata[48:40] !== exp_r.count) begin
                    $error("count: expected %0d actual %0d", exp_r.count, m_tdata[48:40]);
                    errors++;
                end
                if (m_tdata[55:49] !== '0) begin
                    $error("pad: expected 0 actual %h", m_tdata[55:49]);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_op(MODE_REMOVE, 8'hff, '0);
        send_op(MODE_QUERY, 8'd0, '0);
        send_op(MODE_INSERT, 8'd0, 32'h8000_0000);
        send_op(MODE_INSERT, 8'd255, 32'h7fff_ffff);
        send_op(MODE_INSERT, 8'd7, 32'd5);
        send_op(MODE_INSERT, 8'd8, 32'd5);
        send_op(MODE_INSERT, 8'd7, 32'd9);
        send_op(MODE_QUERY, 8'd255, '0);
        send_op(MODE_INCREASE, 8'd7, 32'd5);
        send_op(MODE_INCREASE, 8'd7, 32'd6);
        send_op(MODE_DECREASE, 8'd255, 32'h7fff_ffff);
        send_op(MODE_DECREASE, 8'd255, 32'hffff_0000);
        send_op(MODE_INCREASE, 8'd9, 32'd1);
        send_op(3'd5, 8'd1, 32'd1);
        send_op(3'd6, 8'd2, 32'd1);
        send_op(3'd7, 8'd3, 32'd1);
        repeat (5) send_op(MODE_REMOVE, 8'h55, '0);
    endtask

    task automatic test_capacity_edges();
        write_capacity(2);
        send_op(MODE_INSERT, 8'd1, 32'd3);
        send_op(MODE_INSERT, 8'd0, 32'd4);
        send_op(MODE_INSERT, 8'd2, 32'd5);
        write_capacity(1);
        send_op(MODE_QUERY, 8'd1, '0);
        send_op(MODE_INCREASE, 8'd1, 32'd9);
        send_op(MODE_REMOVE, 8'd0, '0);
        write_capacity(0);
        send_op(MODE_INSERT, 8'd0, 32'd1);
        send_op(MODE_REMOVE, 8'd0, '0);
        write_capacity(511);
        send_op(MODE_REMOVE, 8'd0, '0);
    endtask

    task automatic run_random(int n, int cap, int idle, int stall);
        logic [2:0] mode;
        int cap_eff;
        write_capacity(cap);
        send_idle = idle;
        recv_stall = stall;
        cap_eff = cap < MaxIds ? cap : MaxIds;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) mode = 3'($urandom_range(7));
            else if (heap_count < cap_eff / 2) mode = ($urandom_range(2) == 0) ?
                3'($urandom_range(4)) : MODE_INSERT;
            else mode = 3'($urandom_range(4));
            send_op(mode, ($urandom_range(9) == 0 || cap_eff == 0) ? 8'($urandom_range(255))
                    : 8'($urandom_range(cap_eff - 1)), rand_prio());
            if (i == n / 2 && idle > 0) drain_results();
        end
        send_idle = 0;
        recv_stall = 0;
    endtask

    task automatic test_fill_and_empty();
        write_capacity(256);
        for (int i = 0; i < 256; i++) send_op(MODE_INSERT, 8'(i), $urandom);
        send_op(MODE_INSERT, 8'd3, 32'd0);
        while (heap_count > 0) send_op(MODE_REMOVE, 8'd0, '0);
    endtask

    initial begin
        for (int i = 0; i < MaxIds; i++) present[i] = 1'b0;
        heap_count = 0;
        cap_cfg = CAP_RESET;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_capacity_edges();
        run_random(90, 256, 0, 0);
        run_random(90, 16, 61, 0);
        run_random(90, 5, 0, 61);
        run_random(90, 200, 23, 23);
        run_random(40, 3, 0, 0);
        test_fill_and_empty();
        drain_results();
        $display("Ran %0d operations with %0d results over capacities from 0 to 511,",
                 sent, received);
        $display("covering every mode, rejections, full and empty heap and stalls.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
